// ----- rtl/core/bpa_pkg.sv -----
// Shared types, widths, codes and bit helpers of the bitmap page allocator.
package bpa_pkg;

	localparam int ACTION_W   = 2;
	localparam int FIRST_W    = 12;
	localparam int COUNT_W    = 13;
	localparam int ADDR_W     = 24;
	localparam int USED_W     = 13;
	localparam int TOTAL_W    = 13;
	localparam int WORD_BITS  = 32;
	localparam int OFF_W      = 5;
	localparam int RUN_W      = 6;

	localparam int DEF_NUM_PAGES  = 4096;
	localparam int DEF_PAGE_BYTES = 4096;

	typedef logic [WORD_BITS-1:0] map_word_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_ALLOC = 2'd0,
		ACT_MARK  = 2'd1,
		ACT_FREE  = 2'd2
	} action_t;

	// Index of the lowest set bit; zero for an empty word.
	function automatic logic [OFF_W-1:0] low_index(map_word_t x);
		map_word_t        oh;
		logic [OFF_W-1:0] idx;
		oh  = x & (~x + map_word_t'(1));
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (oh[i]) idx = idx | OFF_W'(i);
		end
		return idx;
	endfunction

	// Count of consecutive ones from bit 0 upwards.
	function automatic logic [RUN_W-1:0] trail_ones(map_word_t x);
		logic [RUN_W-1:0] n;
		if (~x == '0) n = RUN_W'(WORD_BITS);
		else          n = RUN_W'(low_index(~x));
		return n;
	endfunction

	// Count of consecutive ones from the top bit downwards.
	function automatic logic [RUN_W-1:0] lead_ones(map_word_t x);
		map_word_t r;
		for (int i = 0; i < WORD_BITS; i++) begin
			r[i] = x[WORD_BITS-1-i];
		end
		return trail_ones(r);
	endfunction

	// Bit i set where bits i .. i+c-1 of f are all set and lie inside the word.
	function automatic map_word_t fit_mask(map_word_t f, logic [OFF_W-1:0] c);
		map_word_t a1, a2, a4, a8, a16, r;
		a1  = f;
		a2  = a1 & (a1 >> 1);
		a4  = a2 & (a2 >> 2);
		a8  = a4 & (a4 >> 4);
		a16 = a8 & (a8 >> 8);
		r   = '1;
		if (c[0]) r = r & a1;
		if (c[1]) r = r & (a2  >> c[0]);
		if (c[2]) r = r & (a4  >> c[1:0]);
		if (c[3]) r = r & (a8  >> c[2:0]);
		if (c[4]) r = r & (a16 >> c[3:0]);
		return r;
	endfunction

	function automatic logic [RUN_W-1:0] popcount(map_word_t x);
		logic [RUN_W-1:0] n;
		n = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			n = n + RUN_W'(x[i]);
		end
		return n;
	endfunction

endpackage

// ----- rtl/core/bpa_ifs.sv -----
// Request and response channel interfaces of the bitmap page allocator.
interface bpa_req_if;
	import bpa_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [FIRST_W-1:0]  first_page;
	logic [COUNT_W-1:0]  page_count;

	modport source (output valid, action, first_page, page_count, input ready);
	modport sink   (input valid, action, first_page, page_count, output ready);
endinterface

interface bpa_rsp_if;
	import bpa_pkg::*;
	logic               valid;
	logic               ready;
	logic               status;
	logic [ADDR_W-1:0]  address;
	logic [USED_W-1:0]  used_pages;
	logic [TOTAL_W-1:0] total_pages;

	modport source (output valid, status, address, used_pages, total_pages, input ready);
	modport sink   (input valid, status, address, used_pages, total_pages, output ready);
endinterface

// ----- rtl/core/bpa_map_ram.sv -----
// Occupancy map memory: one read and one write port, with a clearing pass after reset.
module bpa_map_ram #(
	parameter int WORDS = 128,
	parameter int WW    = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [WW-1:0]       rd_addr,
	output bpa_pkg::map_word_t  rd_data,
	input  logic                wr_en,
	input  logic [WW-1:0]       wr_addr,
	input  bpa_pkg::map_word_t  wr_data,
	output logic                busy
);
	import bpa_pkg::*;

	map_word_t     mem_q [WORDS];
	map_word_t     rd_data_q;
	logic          clr_busy_q;
	logic [WW-1:0] clr_addr_q;

	logic          wen;
	logic [WW-1:0] waddr;
	map_word_t     wdata;

	// Clearing pass: page zero stays reserved, all else free.
	always_comb begin
		if (clr_busy_q) begin
			wen   = 1'b1;
			waddr = clr_addr_q;
			wdata = (clr_addr_q == '0) ? map_word_t'(1) : '0;
		end else begin
			wen   = wr_en;
			waddr = wr_addr;
			wdata = wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == WW'(WORDS - 1)) clr_busy_q <= 1'b0;
			else                              clr_addr_q <= clr_addr_q + WW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wen) mem_q[waddr] <= wdata;
		if (rd_en) rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;
	assign busy    = clr_busy_q;

endmodule

// ----- rtl/core/bpa_fit_scan.sv -----
// First-fit run finder: evaluates one map word a cycle and carries the open free run.
module bpa_fit_scan #(
	parameter int NUM_PAGES = 4096,
	parameter int WW        = 7,
	parameter int EW        = 14
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      clear,
	input  logic                      valid,
	input  logic [WW-1:0]             word_idx,
	input  bpa_pkg::map_word_t        data,
	input  logic [bpa_pkg::COUNT_W-1:0] count,
	output logic                      found,
	output logic [EW-1:0]             start
);
	import bpa_pkg::*;

	localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int TAIL  = NUM_PAGES % WORD_BITS;
	localparam map_word_t TAIL_MASK = (TAIL == 0) ? '1 : ((map_word_t'(1) << TAIL) - 1);

	logic [EW-1:0]    len_q;
	map_word_t        free_bits;
	map_word_t        fit;
	logic [RUN_W-1:0] low_run;
	logic [EW-1:0]    base;
	logic             carry_hit;
	logic             word_hit;

	always_comb begin
		// Pages past the end of the map count as used.
		free_bits = ~data;
		if (word_idx == WW'(WORDS - 1)) free_bits = free_bits & TAIL_MASK;
		low_run   = trail_ones(free_bits);
		base      = EW'(word_idx) << OFF_W;
		carry_hit = (len_q + EW'(low_run)) >= EW'(count);
		fit       = fit_mask(free_bits, count[OFF_W-1:0]);
		word_hit  = (count < COUNT_W'(WORD_BITS)) && (fit != '0);
		found     = valid && (carry_hit || word_hit);
		// A run reaching in from earlier words always starts lower.
		if (carry_hit) start = base - len_q;
		else           start = base + EW'(low_index(fit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (clear) begin
			len_q <= '0;
		end else if (valid) begin
			if (free_bits == '1) len_q <= len_q + EW'(WORD_BITS);
			else                 len_q <= EW'(lead_ones(free_bits));
		end
	end

endmodule

// ----- rtl/core/bitmap_page_allocator_unit.sv -----
// Top level of the bitmap first-fit page allocator.
//
// Requests arrive on req (action, first_page, page_count); one result per
// request leaves on rsp (status, address, used_pages, total_pages). Both are
// valid/ready channels; a transaction completes when valid and ready are high.
// The map sits in a memory of 32-bit words, one bit per page, with a
// registered read port.
// Allocate scans the map from word 0 at one word a cycle, then writes the run
// back one word a cycle (read, modify, write, with the read of the next word
// overlapping the write of the current one). Mark-used and free skip the scan.
// An allocate that finds no run reads the whole map; mark-used and free
// read and write only the words the run spans; a zero-length or unknown
// request goes straight to the result.
// One request is in work at a time; the next is taken once the result is
// loaded and the block is back in idle.
// After reset a clearing pass writes every map word, during which
// req.ready stays low; page 0 comes out reserved.
// A finished result waits in the output register while the receiver stalls;
// the next request is still taken and worked, and only its result waits.
module bitmap_page_allocator_unit #(
	parameter int NUM_PAGES  = bpa_pkg::DEF_NUM_PAGES,
	parameter int PAGE_BYTES = bpa_pkg::DEF_PAGE_BYTES
) (
	input  logic      clk,
	input  logic      arst_n,
	bpa_req_if.sink   req,
	bpa_rsp_if.source rsp
);
	import bpa_pkg::*;

	localparam int WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PCW   = $clog2(NUM_PAGES + 1);
	localparam int EW    = ((PCW > COUNT_W) ? PCW : COUNT_W) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WSETUP,
		ST_WRITE,
		ST_FLUSH,
		ST_DONE
	} state_t;

	state_t             state_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [EW-1:0]      lo_q;
	logic               set_q;
	logic               status_q;
	logic               alloc_ok_q;
	logic [WW-1:0]      scan_word_q;
	logic               scan_more_q;
	logic [WW-1:0]      first_word_q;
	logic [WW-1:0]      last_word_q;
	logic [WW-1:0]      wr_word_q;
	logic               wr_more_q;
	logic [OFF_W-1:0]   lo_off_q;
	logic [OFF_W-1:0]   hi_off_q;
	logic               rsp_valid_q;
	logic               rsp_status_q;
	logic [ADDR_W-1:0]  rsp_addr_q;
	logic [USED_W-1:0]  rsp_used_q;

	logic [PCW-1:0]     used_q;
	logic               rd_valid_s1;
	logic [WW-1:0]      word_s1;
	map_word_t          diff_s2;
	logic               diff_valid_s2;
	logic               set_s2;

	logic               req_fire;
	action_t            req_act;
	logic               map_busy;
	logic               rd_en;
	logic [WW-1:0]      rd_addr;
	map_word_t          rd_data;
	logic               wr_en;
	map_word_t          wr_data;
	map_word_t          mask;
	logic               scan_valid;
	logic               scan_found;
	logic [EW-1:0]      scan_start;
	logic [EW-1:0]      hi_raw;
	logic [EW-1:0]      hi_end;
	logic [EW-1:0]      last_page;
	logic               out_free;
	logic [ADDR_W-1:0]  addr_calc;

	assign req.ready = (state_q == ST_IDLE) && !map_busy;
	assign req_fire  = req.valid && req.ready;
	assign req_act   = action_t'(req.action);
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Share the read port between the scan and the write-back sweep.
	assign rd_en   = ((state_q == ST_SCAN) && scan_more_q) ||
	                 ((state_q == ST_WRITE) && wr_more_q);
	assign rd_addr = (state_q == ST_SCAN) ? scan_word_q : wr_word_q;

	assign scan_valid = (state_q == ST_SCAN) && rd_valid_s1;

	// Run end, clipped to the map, for the write-back setup.
	always_comb begin
		hi_raw    = lo_q + EW'(cnt_q);
		hi_end    = (hi_raw > EW'(NUM_PAGES)) ? EW'(NUM_PAGES) : hi_raw;
		last_page = hi_end - EW'(1);
	end

	// Modify: trim the run mask at the first and last words.
	always_comb begin
		mask = '1;
		if (word_s1 == first_word_q) mask = mask & ('1 << lo_off_q);
		if (word_s1 == last_word_q)  mask = mask & ('1 >> (OFF_W'(WORD_BITS - 1) - hi_off_q));
		wr_data = set_q ? (rd_data | mask) : (rd_data & ~mask);
		wr_en   = (state_q == ST_WRITE) && rd_valid_s1;
	end

	assign addr_calc = ADDR_W'(ADDR_W'(lo_q) * ADDR_W'(PAGE_BYTES));

	bpa_map_ram #(
		.WORDS (WORDS),
		.WW    (WW)
	) u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (word_s1),
		.wr_data (wr_data),
		.busy    (map_busy)
	);

	bpa_fit_scan #(
		.NUM_PAGES (NUM_PAGES),
		.WW        (WW),
		.EW        (EW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (req_fire),
		.valid    (scan_valid),
		.word_idx (word_s1),
		.data     (rd_data),
		.count    (cnt_q),
		.found    (scan_found),
		.start    (scan_start)
	);

	// Read pipeline; drop the read in flight once the scan has its run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en && !(scan_valid && scan_found);
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= rd_addr;
		diff_s2 <= rd_data ^ wr_data;
		set_s2  <= set_q;
	end

	// Used-page count follows the bits that really changed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_valid_s2 <= 1'b0;
			used_q        <= PCW'(1);
		end else begin
			diff_valid_s2 <= wr_en;
			if (diff_valid_s2) begin
				if (set_s2) used_q <= used_q + PCW'(popcount(diff_s2));
				else        used_q <= used_q - PCW'(popcount(diff_s2));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			lo_q         <= '0;
			set_q        <= 1'b0;
			status_q     <= 1'b0;
			alloc_ok_q   <= 1'b0;
			scan_word_q  <= '0;
			scan_more_q  <= 1'b0;
			first_word_q <= '0;
			last_word_q  <= '0;
			wr_word_q    <= '0;
			wr_more_q    <= 1'b0;
			lo_off_q     <= '0;
			hi_off_q     <= '0;
			rsp_valid_q  <= 1'b0;
			rsp_status_q <= 1'b0;
			rsp_addr_q   <= '0;
			rsp_used_q   <= '0;
		end else begin
			// Drain the output register; a result loading this cycle takes its place.
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) rsp_valid_q <= 1'b0;

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						cnt_q      <= req.page_count;
						lo_q       <= EW'(req.first_page);
						alloc_ok_q <= 1'b0;
						case (req_act) inside
							ACT_ALLOC: begin
								if (req.page_count == '0) begin
									status_q <= 1'b1;
									state_q  <= ST_DONE;
								end else begin
									scan_word_q <= '0;
									scan_more_q <= 1'b1;
									state_q     <= ST_SCAN;
								end
							end
							ACT_MARK, ACT_FREE: begin
								set_q    <= (req_act == ACT_MARK);
								status_q <= 1'b0;
								if (req.page_count == '0 ||
								    EW'(req.first_page) >= EW'(NUM_PAGES)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_WSETUP;
								end
							end
							default: begin
								status_q <= 1'b1;
								state_q  <= ST_DONE;
							end
						endcase
					end
				end

				// Reads stop with the state; a stale scan_more_q is reloaded on the next allocate.
				ST_SCAN: begin
					if (scan_more_q) begin
						if (scan_word_q == WW'(WORDS - 1)) scan_more_q <= 1'b0;
						else                               scan_word_q <= scan_word_q + WW'(1);
					end
					if (scan_valid && scan_found) begin
						lo_q        <= scan_start;
						set_q       <= 1'b1;
						alloc_ok_q  <= 1'b1;
						status_q    <= 1'b0;
						state_q     <= ST_WSETUP;
					end else if (scan_valid && word_s1 == WW'(WORDS - 1)) begin
						status_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end

				ST_WSETUP: begin
					first_word_q <= WW'(lo_q >> OFF_W);
					wr_word_q    <= WW'(lo_q >> OFF_W);
					last_word_q  <= WW'(last_page >> OFF_W);
					lo_off_q     <= lo_q[OFF_W-1:0];
					hi_off_q     <= last_page[OFF_W-1:0];
					wr_more_q    <= 1'b1;
					state_q      <= ST_WRITE;
				end

				ST_WRITE: begin
					if (wr_more_q) begin
						if (wr_word_q == last_word_q) wr_more_q <= 1'b0;
						else                          wr_word_q <= wr_word_q + WW'(1);
					end
					if (rd_valid_s1 && word_s1 == last_word_q) state_q <= ST_FLUSH;
				end

				// Let the last count update land.
				ST_FLUSH: begin
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						rsp_status_q <= status_q;
						rsp_addr_q   <= alloc_ok_q ? addr_calc : '0;
						rsp_used_q   <= USED_W'(used_q);
						state_q      <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.address     = rsp_addr_q;
	assign rsp.used_pages  = rsp_used_q;
	assign rsp.total_pages = TOTAL_W'(NUM_PAGES);

	// Requests are never taken while the clearing pass runs.
	a_no_req_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		map_busy |-> !req.ready)
		else $error("request accepted during map clearing pass");

	// A read and a write never hit the same map word in one cycle.
	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (word_s1 != rd_addr))
		else $error("read and write of the same map word in one cycle");

	// The write-back sweep stays inside the run.
	a_sweep_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (word_s1 >= first_word_q && word_s1 <= last_word_q))
		else $error("write-back outside the run");

	// The used count never passes the map size.
	a_used_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= PCW'(NUM_PAGES))
		else $error("used page count exceeds map size");

	// A result is only loaded once the register is free or being drained.
	a_result_not_lost: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && !rsp.ready) |=> rsp_valid_q)
		else $error("pending result dropped");

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the bitmap first-fit page allocator.
`timescale 1ns / 100ps

module testbench;
	import bpa_pkg::*;

	localparam int NUM_PAGES  = DEF_NUM_PAGES;
	localparam int PAGE_BYTES = DEF_PAGE_BYTES;

	// Action code the block does not define; it must be refused.
	localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

	localparam int RANDOM_ITEMS   = 700;
	localparam int CALM_ITEMS     = 80;     // no idling over the last stretch
	localparam int PRESSURE_AT    = 150;    // random item that triggers the long stall
	localparam int PRESSURE_LEN   = 600;    // cycles the receiver holds off
	localparam int WIPE_EVERY     = 200;    // random items between whole-map clears
	localparam int TAIL_CYCLES    = 300;    // beyond the longest allocate latency
	localparam int CYCLE_LIMIT    = 1000000;

	typedef struct packed {
		logic               status;
		logic [ADDR_W-1:0]  address;
		logic [USED_W-1:0]  used_pages;
		logic [TOTAL_W-1:0] total_pages;
	} alloc_result_t;

	typedef struct {
		int unsigned first;
		int unsigned count;
	} page_run_t;

	// Mirror of the occupancy map, plus the queue of results still owed.
	class page_map_scoreboard;
		bit            occupied [NUM_PAGES];
		int unsigned   used;
		alloc_result_t owed_q [$];
		int unsigned   checked;
		int unsigned   failures;
		int unsigned   granted;
		int unsigned   refused;

		function void clear_map();
			foreach (occupied[p]) occupied[p] = (p == 0);
			used = 1;
		endfunction

		function void write_run(int unsigned first, int unsigned count, bit v);
			for (int unsigned p = first; p < NUM_PAGES && p - first < count; p++) begin
				if (v && !occupied[p]) begin
					occupied[p] = 1'b1;
					used++;
				end else if (!v && occupied[p]) begin
					occupied[p] = 1'b0;
					used--;
				end
			end
		endfunction

		// Lowest start of count contiguous free pages.
		function bit find_run(int unsigned count, output int unsigned start);
			int unsigned len;
			len   = 0;
			start = 0;
			for (int unsigned p = 0; p < NUM_PAGES; p++) begin
				if (occupied[p]) begin
					len = 0;
				end else begin
					len++;
					if (len == count) begin
						start = p + 1 - count;
						return 1'b1;
					end
				end
			end
			return 1'b0;
		endfunction

		function alloc_result_t note_request(logic [ACTION_W-1:0] action,
				logic [FIRST_W-1:0] first, logic [COUNT_W-1:0] count);
			alloc_result_t r;
			int unsigned   start;
			r.status  = 1'b0;
			r.address = '0;
			case (action)
				ACT_ALLOC: begin
					if (count == 0 || !find_run(count, start)) begin
						r.status = 1'b1;
						refused++;
					end else begin
						write_run(start, count, 1'b1);
						r.address = ADDR_W'(start * PAGE_BYTES);
						granted++;
					end
				end
				ACT_MARK: write_run(first, count, 1'b1);
				ACT_FREE: write_run(first, count, 1'b0);
				default:  r.status = 1'b1;
			endcase
			r.used_pages  = USED_W'(used);
			r.total_pages = TOTAL_W'(NUM_PAGES);
			owed_q.push_back(r);
			return r;
		endfunction

		function void check_result(alloc_result_t got);
			alloc_result_t want;
			if (owed_q.size() == 0) begin
				$error("result arrived with no request outstanding");
				failures++;
				return;
			end
			want = owed_q.pop_front();
			checked++;
			if (got.status !== want.status) begin
				$error("status mismatch: expected %0d, actual %0d", want.status, got.status);
				failures++;
			end
			if (got.address !== want.address) begin
				$error("address mismatch: expected 0x%06h, actual 0x%06h",
					want.address, got.address);
				failures++;
			end
			if (got.used_pages !== want.used_pages) begin
				$error("used_pages mismatch: expected %0d, actual %0d",
					want.used_pages, got.used_pages);
				failures++;
			end
			if (got.total_pages !== want.total_pages) begin
				$error("total_pages mismatch: expected %0d, actual %0d",
					want.total_pages, got.total_pages);
				failures++;
			end
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	bpa_req_if req_ch ();
	bpa_rsp_if rsp_ch ();

	bitmap_page_allocator_unit #(
		.NUM_PAGES  (NUM_PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	page_map_scoreboard sb = new;

	page_run_t   live_runs [$];     // runs handed out and not yet given back
	bit          calm          = 1'b0;
	bit          pressure_req  = 1'b0;
	bit          pressure_done = 1'b0;
	int unsigned sent          = 0;
	int unsigned cycle_count   = 0;

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Drive one request and hold it until the block takes the transaction.
	// An idle gap, when drawn, drops valid first; otherwise valid stays high
	// straight into the next transaction with a single assignment this step.
	task automatic send_request(input logic [ACTION_W-1:0] action,
			input logic [FIRST_W-1:0] first, input logic [COUNT_W-1:0] count,
			output alloc_result_t owed);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.action     <= action;
		req_ch.first_page <= first;
		req_ch.page_count <= count;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		owed = sb.note_request(action, first, count);
		sent++;
	endtask

	// Allocate and keep the granted run so that a later free can return it.
	task automatic alloc_pages(input int unsigned count);
		alloc_result_t owed;
		page_run_t     run;
		send_request(ACT_ALLOC, FIRST_W'($urandom), COUNT_W'(count), owed);
		if (owed.status == 1'b0) begin
			run.first = owed.address / PAGE_BYTES;
			run.count = count;
			live_runs.push_back(run);
		end
	endtask

	// Mostly small allocations, so that scans stay short and the map fragments.
	function automatic int unsigned pick_alloc_size();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 85) return $urandom_range(1, 32);
		if (roll < 97) return $urandom_range(33, 300);
		return $urandom_range(301, NUM_PAGES);
	endfunction

	function automatic int unsigned pick_run_count();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 80) return $urandom_range(0, 64);
		if (roll < 95) return $urandom_range(65, 600);
		return $urandom_range(0, (1 << COUNT_W) - 1);
	endfunction

	// Receiver: random ready bursts, one long hold-off on request, and a
	// steady ready over the calm stretch at the end.
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge clk);
		forever begin
			if (pressure_req && !pressure_done) begin
				pressure_done = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (PRESSURE_LEN) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 24)) @(posedge clk);
			end
		end
	end

	// Sample completed result transactions with the values from before the edge.
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			sb.check_result({rsp_ch.status, rsp_ch.address,
				rsp_ch.used_pages, rsp_ch.total_pages});
		end
	end

	// Watchdog: covers the clearing pass, the long stall and worst-case scans.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, sb.pending());
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		alloc_result_t owed;
		page_run_t     run;
		int unsigned   roll;
		int unsigned   idx;

		arst_n            = 1'b0;
		req_ch.valid      = 1'b0;
		req_ch.action     = ACT_ALLOC;
		req_ch.first_page = '0;
		req_ch.page_count = '0;
		sb.clear_map();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: field extremes, every action and the corner cases.
		send_request(ACT_ALLOC,  12'd0,    13'd0,    owed);  // zero-length allocate
		send_request(ACT_ALLOC,  12'd0,    13'd1,    owed);  // lands just past the reserved page
		send_request(ACT_ALLOC,  12'd4095, 13'd31,   owed);  // crosses a word boundary
		send_request(ACT_ALLOC,  12'd0,    13'd4096, owed);  // no room for the whole map
		send_request(ACT_ALLOC,  12'd0,    13'd8191, owed);  // larger than the map
		send_request(ACT_MARK,   12'd4095, 13'd8191, owed);  // clipped at the end of the map
		send_request(ACT_FREE,   12'd4095, 13'd1,    owed);
		send_request(ACT_MARK,   12'd200,  13'd0,    owed);  // zero-length mark
		send_request(ACT_FREE,   12'd1,    13'd0,    owed);  // zero-length free
		send_request(ACT_UNUSED, 12'd4095, 13'd8191, owed);
		send_request(ACT_MARK,   12'd1,    13'd4,    owed);  // pages already in use
		send_request(ACT_FREE,   12'd100,  13'd10,   owed);  // pages already free
		send_request(ACT_FREE,   12'd0,    13'd1,    owed);  // release the reserved page
		send_request(ACT_ALLOC,  12'd0,    13'd1,    owed);  // page zero comes back
		send_request(ACT_FREE,   12'd0,    13'd4096, owed);
		send_request(ACT_ALLOC,  12'd0,    13'd4096, owed);  // the whole map at once
		send_request(ACT_ALLOC,  12'd0,    13'd1,    owed);  // map full
		send_request(ACT_FREE,   12'd0,    13'd8191, owed);
		send_request(ACT_MARK,   12'd0,    13'd1,    owed);
		send_request(ACT_ALLOC,  12'd0,    13'd64,   owed);
		send_request(ACT_ALLOC,  12'd0,    13'd33,   owed);
		send_request(ACT_FREE,   12'd2048, 13'd4096, owed);
		send_request(ACT_ALLOC,  12'd0,    13'd2048, owed);
		send_request(ACT_UNUSED, 12'd0,    13'd0,    owed);
		send_request(ACT_FREE,   12'd1,    13'd4095, owed);  // back to the reset picture

		// Random part: mostly allocate and give back, with stray runs and noise.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
			if (n == PRESSURE_AT) pressure_req = 1'b1;
			if (n % WIPE_EVERY == WIPE_EVERY - 1) begin
				// Clear everything and reserve page zero again.
				send_request(ACT_FREE, 12'd0, 13'd4096, owed);
				send_request(ACT_MARK, 12'd0, 13'd1, owed);
				live_runs.delete();
			end
			roll = $urandom_range(0, 99);
			// Steer towards freeing when the map runs full.
			if (sb.used > 3200) roll = (live_runs.size() > 0) ? 45 : 78;
			if (roll < 40) begin
				alloc_pages(pick_alloc_size());
			end else if (roll < 65 && live_runs.size() > 0) begin
				idx = $urandom_range(0, live_runs.size() - 1);
				run = live_runs[idx];
				live_runs.delete(idx);
				send_request(ACT_FREE, FIRST_W'(run.first), COUNT_W'(run.count), owed);
			end else if (roll < 73) begin
				send_request(ACT_MARK, FIRST_W'($urandom), COUNT_W'(pick_run_count()), owed);
			end else if (roll < 83) begin
				send_request(ACT_FREE, FIRST_W'($urandom), COUNT_W'(pick_run_count()), owed);
			end else if (roll < 87) begin
				send_request(ACT_UNUSED, FIRST_W'($urandom), COUNT_W'($urandom), owed);
			end else if (roll < 90) begin
				send_request(ACTION_W'($urandom), FIRST_W'($urandom),
					COUNT_W'($urandom), owed);
			end else begin
				alloc_pages($urandom_range(1, 8));
			end
		end
		req_ch.valid <= 1'b0;

		// Drain every owed result, then let the block settle.
		while (sb.pending() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d requests and %0d checked results over %0d cycles",
			sent, sb.checked, cycle_count);
		$display("Allocations granted %0d, refused %0d; pages in use at the end %0d",
			sb.granted, sb.refused, sb.used);
		if (sb.failures == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
